/* hdl/btb_lru_pkg.sv */
// Shared types and constants for the set-associative branch target buffer.
// No dependencies; imported by branch_target_buffer_lru.
`default_nettype none

package btb_lru_pkg;

  localparam int unsigned DEF_NUM_SETS = 1024;
  localparam int unsigned DEF_NUM_WAYS = 12;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned WAY_W   = 4;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_EVAL  = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_WRITE = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

/* hdl/branch_target_buffer_lru.sv */
// Set-associative branch target buffer with timestamp-based LRU replacement.
// Depends on btb_lru_pkg.
//
// One item at a time. After reset the block clears every set with busy high.
// An accepted item is split into set and tag. For a power-of-two NUM_SETS
// this is immediate. Otherwise a reciprocal-multiply divider takes the
// address 16 bits at a time, forming each quotient digit, then the remainder.
// Then the READ state reads the whole set row from the memory, and EVAL
// compares it and writes back on a lookup hit or an insert into a set with an
// empty way; a lookup, or such an insert, ends there with the result strobe.
// An insert into a full set then scans the stamps one way per cycle in SCAN
// and writes the oldest way in WRITE. The result is on hit_o/way_o for
// exactly one cycle with result_valid_o, and there is no back-pressure. busy
// is already low in that cycle, so the next start can be taken there.
`default_nettype none

module branch_target_buffer_lru #(
  parameter int unsigned NUM_SETS = btb_lru_pkg::DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS = btb_lru_pkg::DEF_NUM_WAYS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           mode_i,
  input  wire logic [btb_lru_pkg::ADDR_W-1:0]  address_i,
  input  wire logic [btb_lru_pkg::STAMP_W-1:0] access_cycle_i,
  output logic                                result_valid_o,
  output logic                                hit_o,
  output logic [btb_lru_pkg::WAY_W-1:0]        way_o
);
  import btb_lru_pkg::*;

  localparam int unsigned SET_W   = $clog2(NUM_SETS);
  localparam int unsigned TAG_W   = ADDR_W - $clog2(NUM_SETS + 1) + 1;
  localparam int unsigned WAY_IW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned ROW_W   = NUM_WAYS * (1 + TAG_W + STAMP_W);
  localparam bit          IS_POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;
  localparam int unsigned DIG_W   = 16;
  localparam int unsigned DIGITS  = ADDR_W / DIG_W;
  localparam int unsigned BIT_W   = $clog2(2 * DIGITS);
  localparam int unsigned REC_SH  = 2 * DIG_W + SET_W;
  localparam logic [2*DIG_W:0]    REC_M    = (2 * DIG_W + 1)'(
      ((65'(1) << REC_SH) + 65'(NUM_SETS) - 65'(1)) / 65'(NUM_SETS));
  localparam logic [SET_W-1:0]    SET_LAST = SET_W'(NUM_SETS - 1);
  localparam logic [WAY_IW-1:0]   WAY_LAST = WAY_IW'(NUM_WAYS - 1);
  localparam logic [BIT_W-1:0]    BIT_LAST = BIT_W'(2 * DIGITS - 1);

  state_e state_q, state_d;

  logic [SET_W-1:0]   clr_q;
  logic [BIT_W-1:0]   bit_q;
  logic [WAY_IW-1:0]  cnt_q;
  logic [WAY_IW-1:0]  pick_q;
  logic [STAMP_W-1:0] best_q;
  logic               mode_q;
  logic [ADDR_W-1:0]  quo_q;
  logic [SET_W-1:0]   rem_q;
  logic [DIG_W-1:0]   qd_q;
  logic [STAMP_W-1:0] cycle_q;
  logic               res_valid_q;
  logic               hit_q;
  logic [WAY_W-1:0]   way_q;

  logic [ROW_W-1:0]   mem_q [NUM_SETS];
  logic [ROW_W-1:0]   rd_q;

  logic [SET_W-1:0]   set_idx;
  logic [TAG_W-1:0]   tag_idx;

  logic [2*DIG_W-1:0] div_y;
  logic [4*DIG_W:0]   div_p;
  logic [DIG_W-1:0]   qd_d;
  logic [SET_W-1:0]   rem_d;

  logic [NUM_WAYS-1:0]              rd_valid;
  logic [NUM_WAYS-1:0][TAG_W-1:0]   rd_tag;
  logic [NUM_WAYS-1:0][STAMP_W-1:0] rd_stamp;
  logic [NUM_WAYS-1:0]              wr_valid;
  logic [NUM_WAYS-1:0][TAG_W-1:0]   wr_tag;
  logic [NUM_WAYS-1:0][STAMP_W-1:0] wr_stamp;

  logic               hit_any;
  logic [WAY_IW-1:0]  hit_way;
  logic               empty_any;
  logic [WAY_IW-1:0]  empty_way;
  logic [WAY_IW-1:0]  wsel;
  logic               mem_we;
  logic               rd_en;
  logic [SET_W-1:0]   wr_addr;
  logic [ROW_W-1:0]   wr_row;
  logic               eval_write;

  assign set_idx = IS_POW2 ? quo_q[SET_W-1:0] : rem_q;
  assign tag_idx = IS_POW2 ? TAG_W'(quo_q >> SET_W) : quo_q[TAG_W-1:0];

  assign div_y = {DIG_W'(rem_q), quo_q[ADDR_W-1 -: DIG_W]};
  assign div_p = (4 * DIG_W + 1)'(div_y) * (4 * DIG_W + 1)'(REC_M);
  assign qd_d  = DIG_W'(div_p >> REC_SH);
  assign rem_d = SET_W'(div_y - (2 * DIG_W)'(qd_q) * (2 * DIG_W)'(NUM_SETS));

  assign {rd_stamp, rd_tag, rd_valid} = rd_q;

  always_comb begin
    hit_any   = 1'b0;
    hit_way   = '0;
    empty_any = 1'b0;
    empty_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rd_valid[w] && rd_tag[w] == tag_idx) begin
        hit_any = 1'b1;
        hit_way = WAY_IW'(w);
      end
      if (!rd_valid[w]) begin
        empty_any = 1'b1;
        empty_way = WAY_IW'(w);
      end
    end
  end

  always_comb begin
    if (state_q == ST_WRITE) begin
      wsel = pick_q;
    end else if (mode_q == MODE_LOOKUP) begin
      wsel = hit_way;
    end else begin
      wsel = empty_way;
    end
  end

  assign eval_write = (mode_q == MODE_LOOKUP) ? hit_any : (empty_any || NUM_WAYS == 1);

  always_comb begin
    wr_valid = rd_valid;
    wr_tag   = rd_tag;
    wr_stamp = rd_stamp;
    if (state_q == ST_CLEAR) begin
      wr_valid = '0;
      wr_tag   = '0;
      wr_stamp = '0;
    end else begin
      wr_valid[wsel] = 1'b1;
      wr_stamp[wsel] = cycle_q;
      if (mode_q == MODE_INSERT) begin
        wr_tag[wsel] = tag_idx;
      end
    end
  end

  assign wr_row  = {wr_stamp, wr_tag, wr_valid};
  assign wr_addr = (state_q == ST_CLEAR) ? clr_q : set_idx;
  assign rd_en   = state_q == ST_READ;
  assign mem_we  = (state_q == ST_CLEAR) || (state_q == ST_WRITE) ||
                   ((state_q == ST_EVAL) && eval_write);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_q <= mem_q[set_idx];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == SET_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = IS_POW2 ? ST_READ : ST_DIV;
      end
      ST_DIV: begin
        if (bit_q == BIT_LAST) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (mode_q == MODE_INSERT && !eval_write) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (cnt_q == WAY_LAST) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      bit_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_WRITE) ||
                     ((state_q == ST_EVAL) && (mode_q == MODE_LOOKUP || eval_write));
      case (state_q)
        ST_CLEAR: clr_q <= clr_q + 1'b1;
        ST_IDLE:  bit_q <= '0;
        ST_DIV:   bit_q <= bit_q + 1'b1;
        ST_EVAL:  cnt_q <= WAY_IW'(1);
        ST_SCAN:  cnt_q <= cnt_q + 1'b1;
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          mode_q  <= mode_i;
          quo_q   <= address_i;
          rem_q   <= '0;
          cycle_q <= access_cycle_i;
        end
      end
      ST_DIV: begin
        if (!bit_q[0]) begin
          qd_q <= qd_d;
        end else begin
          rem_q <= rem_d;
          quo_q <= {quo_q[ADDR_W-DIG_W-1:0], qd_q};
        end
      end
      ST_EVAL: begin
        best_q <= rd_stamp[0];
        pick_q <= '0;
        hit_q  <= (mode_q == MODE_LOOKUP) && hit_any;
        way_q  <= (mode_q == MODE_LOOKUP && !hit_any) ? '0 : WAY_W'(wsel);
      end
      ST_SCAN: begin
        if (rd_stamp[cnt_q] < best_q) begin
          best_q <= rd_stamp[cnt_q];
          pick_q <= cnt_q;
        end
      end
      ST_WRITE: begin
        hit_q <= 1'b0;
        way_q <= WAY_W'(pick_q);
      end
      default: begin
        hit_q <= hit_q;
      end
    endcase
  end

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = res_valid_q;
  assign hit_o          = hit_q;
  assign way_o          = way_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ($past(state_q) == ST_EVAL || $past(state_q) == ST_WRITE))
    else $error("result strobe without evaluate or write");

  a_hit_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && hit_q |-> mode_q == MODE_LOOKUP)
    else $error("hit reported for insert");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mem_we)
    else $error("memory write while idle");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> busy && !res_valid_q)
    else $error("clearing pass not blocking");

endmodule

`default_nettype wire
